@@ hdl/round_robin_service_queue_defines.svh @@
// Assertion macros shared by the round-robin service queue RTL.
`ifndef ROUND_ROBIN_SERVICE_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_SERVICE_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define RRSQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed: same-cycle property.");
`define RRSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed: next-cycle property.");
`else
`define RRSQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define RRSQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/rrsq_pkg.sv @@
// Types, codes and defaults of the round-robin service queue.
package rrsq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT = 16;
   localparam int FIELD_W = 16;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SERVE = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_ZERO_UNITS = 2'd3;

   typedef struct packed {
      logic               opcode;
      logic [FIELD_W-1:0] client_id;
      logic [FIELD_W-1:0] work_units;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] served_id;
      logic [FIELD_W-1:0] units_before;
      logic               departed;
      logic [1:0]         status;
   } rsp_type;

endpackage

@@ hdl/rrsq_stream_if.sv @@
// Valid/ready stream interface carrying one item per handshake.
interface rrsq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/rrsq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rrsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/round_robin_service_queue.sv @@
// Round-robin service queue: a ring of clients served one work unit at a time.
//
//   Channel   Direction  Handshake          Payload
//   req_chan  in         valid/ready        opcode, client_id, work_units
//   rsp_chan  out        valid/ready        served_id, units_before, departed, status
//
// Every request is handled in the cycle it is accepted and its item waits in the result
// register, so one request per cycle is sustained while the result register is free or taken.
// The ring lives in a RAM with a registered read; the next head slot is read every cycle
// and a write to that slot at the same edge is bypassed around the RAM.
// Reset is synchronous and clears the pointers, the count, the bypass and the valid flag.
// A stalled result holds its item; the input is ready while the result is free or taken.
`include "round_robin_service_queue_defines.svh"

module round_robin_service_queue #(
   parameter int QUEUE_DEPTH = rrsq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS = rrsq_pkg::ID_BITS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   rrsq_stream_if.sink   req_chan,
   rrsq_stream_if.source rsp_chan
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (ID_BITS < rrsq_pkg::FIELD_W) ? ID_BITS : rrsq_pkg::FIELD_W;
   localparam int UW = rrsq_pkg::FIELD_W;
   localparam int EW = IW + UW;
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [OW-1:0] FULL_COUNT = OW'(QUEUE_DEPTH);

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
      logic [AW-1:0] result;
      result = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      return result;
   endfunction

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [OW-1:0] occupancy_ff, occupancy_in;
   logic          bypass_ff, bypass_in;
   logic [EW-1:0] bypass_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rrsq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          wr_en;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] ram_rd_data;
   logic [EW-1:0] head_entry;
   logic [IW-1:0] head_id;
   logic [UW-1:0] head_units;
   logic          ring_bounds;
   logic          add_taken;
   rrsq_pkg::req_type req;

   assign req = req_chan.payload;
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   assign head_entry = bypass_ff ? bypass_data_ff : ram_rd_data;
   assign head_id = head_entry[EW-1:UW];
   assign head_units = head_entry[UW-1:0];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occupancy_in = occupancy_ff;
      wr_en = 1'b0;
      wr_data = {req.client_id[IW-1:0], req.work_units};
      rsp_data_in = '0;
      rsp_data_in.status = rrsq_pkg::STATUS_OK;
      if (accept) begin
         case (req.opcode)
            rrsq_pkg::OP_ADD: begin
               if (req.work_units == '0) begin
                  rsp_data_in.status = rrsq_pkg::STATUS_ZERO_UNITS;
               end else if (occupancy_ff == FULL_COUNT) begin
                  rsp_data_in.status = rrsq_pkg::STATUS_FULL;
               end else begin
                  wr_en = 1'b1;
                  tail_in = next_slot(tail_ff);
                  occupancy_in = occupancy_ff + 1'b1;
               end
            end
            default: begin
               if (occupancy_ff == '0) begin
                  rsp_data_in.status = rrsq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_data_in.served_id = rrsq_pkg::FIELD_W'(head_id);
                  rsp_data_in.units_before = head_units;
                  head_in = next_slot(head_ff);
                  if (head_units <= UW'(1)) begin
                     rsp_data_in.departed = 1'b1;
                     occupancy_in = occupancy_ff - 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = {head_id, head_units - 1'b1};
                     tail_in = next_slot(tail_ff);
                  end
               end
            end
         endcase
      end
   end

   // The RAM reads the next head slot; a write landing there at the same edge is bypassed.
   assign bypass_in = wr_en && (tail_ff == head_in);
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occupancy_ff <= '0;
         bypass_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occupancy_ff <= occupancy_in;
         bypass_ff <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bypass_data_ff <= wr_data;
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   rrsq_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(wr_data),
      .rd_addr(head_in),
      .rd_data(ram_rd_data)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign ring_bounds = (occupancy_ff == '0) || (occupancy_ff == FULL_COUNT);
   assign add_taken = accept && (req.opcode == rrsq_pkg::OP_ADD)
                      && (rsp_data_in.status == rrsq_pkg::STATUS_OK);

   `RRSQ_ASSERT_SAME(a_occupancy_bound, clock, reset, 1'b1, occupancy_ff <= FULL_COUNT)
   `RRSQ_ASSERT_SAME(a_pointers_meet, clock, reset, ring_bounds, head_ff == tail_ff)
   `RRSQ_ASSERT_NEXT(a_add_grows, clock, reset, add_taken, occupancy_ff == $past(occupancy_ff) + 1'b1)

endmodule
